/* hw/rtl/mnns_pkg.sv */
// Package for the masked nearest-neighbour select block.
// Holds the field widths, payload types and the distance-pipe control struct.
// No dependencies.
package mnns_pkg;

    localparam int INDEX_WIDTH = 24;
    localparam int COORD_WIDTH = 24;
    localparam int DIST_WIDTH  = 52;

    // |a - b| of two signed coordinates always fits in COORD_WIDTH bits
    localparam int MAG_WIDTH  = COORD_WIDTH;
    localparam int SQ_WIDTH   = 2 * MAG_WIDTH;
    localparam int SUM_WIDTH  = SQ_WIDTH + 2;
    localparam int WIDE_WIDTH = (SUM_WIDTH > DIST_WIDTH) ? SUM_WIDTH : DIST_WIDTH;

    typedef logic [INDEX_WIDTH-1:0]        t_index;
    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic [DIST_WIDTH-1:0]         t_dist;

    localparam t_dist                 DIST_MAX      = '1;
    localparam logic [WIDE_WIDTH-1:0] DIST_MAX_WIDE = WIDE_WIDTH'(DIST_MAX);

    // load enables of the three distance-pipe register stages
    typedef struct packed {
        logic ld_in;
        logic ld_sq;
        logic ld_sum;
    } t_dist_ctl;

endpackage

/* hw/rtl/mnns_dist.sv */
// Squared-distance datapath: coordinate register, per-axis square register,
// saturated sum register. Depends on mnns_pkg; load enables come from the top.
module mnns_dist (
    input  logic                i_clk,
    input  mnns_pkg::t_dist_ctl i_ctl,
    input  mnns_pkg::t_coord    i_tx,
    input  mnns_pkg::t_coord    i_ty,
    input  mnns_pkg::t_coord    i_tz,
    input  mnns_pkg::t_coord    i_nx,
    input  mnns_pkg::t_coord    i_ny,
    input  mnns_pkg::t_coord    i_nz,
    output mnns_pkg::t_dist     o_dist
);

    localparam int CW = mnns_pkg::COORD_WIDTH;
    localparam int MW = mnns_pkg::MAG_WIDTH;
    localparam int SW = mnns_pkg::SQ_WIDTH;
    localparam int WW = mnns_pkg::WIDE_WIDTH;

    mnns_pkg::t_coord r_t [3];
    mnns_pkg::t_coord r_n [3];
    logic [SW-1:0]    r_sq [3];
    logic [SW-1:0]    n_sq [3];
    mnns_pkg::t_dist  r_dist;
    logic [WW-1:0]    w_sum;
    mnns_pkg::t_dist  n_dist;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in) begin
            r_t[0] <= i_tx;
            r_t[1] <= i_ty;
            r_t[2] <= i_tz;
            r_n[0] <= i_nx;
            r_n[1] <= i_ny;
            r_n[2] <= i_nz;
        end
    end

    // one exact square per axis
    always_comb begin
        logic signed [CW:0] diff;
        logic [MW-1:0]      mag;
        for (int a = 0; a < 3; a++) begin
            diff  = {r_t[a][CW-1], r_t[a]} - {r_n[a][CW-1], r_n[a]};
            mag   = diff[CW] ? MW'(-diff) : MW'(diff);
            n_sq[a] = SW'(mag) * SW'(mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sq) begin
            r_sq <= n_sq;
        end
    end

    // clamp the sum at the top of the distance range
    assign w_sum  = WW'(r_sq[0]) + WW'(r_sq[1]) + WW'(r_sq[2]);
    assign n_dist = (w_sum >= mnns_pkg::DIST_MAX_WIDE) ? mnns_pkg::DIST_MAX
                                                        : w_sum[mnns_pkg::DIST_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sum) begin
            r_dist <= n_dist;
        end
    end

    assign o_dist = r_dist;

endmodule

/* hw/rtl/masked_nearest_neighbour_select.sv */
// Masked nearest-neighbour select, top level.
// Depends on mnns_pkg and mnns_dist.
//
// Streams the candidate neighbours of one target point, one transaction per
// candidate, and on the candidate flagged last emits one result transaction:
// the target index of that last candidate and the index of the best
// candidate of the group. Best means: a neighbour whose mask equals the
// target mask beats one that does not; then the smaller exact squared
// distance wins (clamped at 2^52-1); then the lower index; on a full tie the
// earlier candidate stays. The block takes one candidate every clock while
// o_stall is low. A candidate passes an input register, a square register
// (one multiplier per axis) and a sum register before it meets the kept best,
// and the result is then captured in the output register. The stages hold on
// their own: input keeps flowing while a result waits in the output
// register, and only a last candidate that reaches the compare stage while
// the output register is still full holds the pipe. There are no
// configuration registers.
module masked_nearest_neighbour_select (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_valid,
    output logic                o_stall,
    input  mnns_pkg::t_index    i_target_index,
    input  mnns_pkg::t_coord    i_target_x,
    input  mnns_pkg::t_coord    i_target_y,
    input  mnns_pkg::t_coord    i_target_z,
    input  logic                i_target_mask,
    input  mnns_pkg::t_coord    i_neighbour_x,
    input  mnns_pkg::t_coord    i_neighbour_y,
    input  mnns_pkg::t_coord    i_neighbour_z,
    input  logic                i_neighbour_mask,
    input  mnns_pkg::t_index    i_neighbour_index,
    input  logic                i_last,

    output logic                o_valid,
    input  logic                i_stall,
    output mnns_pkg::t_index    o_out_target_index,
    output mnns_pkg::t_index    o_chosen_index,
    output logic                o_chosen_matches
);

    // stage valid bits: input, square, sum
    logic r_v1, r_v2, r_v3;
    logic w_rdy1, w_rdy2, w_rdy3, w_consume;

    // side payload riding along with the distance pipe
    mnns_pkg::t_index r1_tidx, r2_tidx, r3_tidx;
    mnns_pkg::t_index r1_nidx, r2_nidx, r3_nidx;
    logic             r1_match, r2_match, r3_match;
    logic             r1_last, r2_last, r3_last;

    mnns_pkg::t_dist_ctl w_ctl;
    mnns_pkg::t_dist     w_dist;

    // kept best of the current group
    logic             r_have_best, n_have_best;
    logic             r_best_matches, n_best_matches;
    mnns_pkg::t_dist  r_best_dist, n_best_dist;
    mnns_pkg::t_index r_best_index, n_best_index;
    logic             w_take;

    // output register
    logic             r_o_valid;
    mnns_pkg::t_index r_o_tidx, r_o_cidx;
    logic             r_o_match;

    // The compare stage takes its candidate unless it closes a group and the
    // output register is full and not being drained this cycle.
    assign w_consume = !(r3_last && r_o_valid && i_stall);
    assign w_rdy3    = !r_v3 || w_consume;
    assign w_rdy2    = !r_v2 || w_rdy3;
    assign w_rdy1    = !r_v1 || w_rdy2;
    assign o_stall   = !w_rdy1;

    assign w_ctl.ld_in  = w_rdy1 && i_valid;
    assign w_ctl.ld_sq  = w_rdy2 && r_v1;
    assign w_ctl.ld_sum = w_rdy3 && r_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // advance the side payload with the same enables as the distance pipe
    always_ff @(posedge i_clk) begin
        if (w_ctl.ld_in) begin
            r1_tidx  <= i_target_index;
            r1_nidx  <= i_neighbour_index;
            r1_match <= (i_target_mask == i_neighbour_mask);
            r1_last  <= i_last;
        end
        if (w_ctl.ld_sq) begin
            r2_tidx  <= r1_tidx;
            r2_nidx  <= r1_nidx;
            r2_match <= r1_match;
            r2_last  <= r1_last;
        end
        if (w_ctl.ld_sum) begin
            r3_tidx  <= r2_tidx;
            r3_nidx  <= r2_nidx;
            r3_match <= r2_match;
            r3_last  <= r2_last;
        end
    end

    mnns_dist u_dist (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_tx   (i_target_x),
        .i_ty   (i_target_y),
        .i_tz   (i_target_z),
        .i_nx   (i_neighbour_x),
        .i_ny   (i_neighbour_y),
        .i_nz   (i_neighbour_z),
        .o_dist (w_dist)
    );

    // ranking: mask match, then distance, then index
    always_comb begin
        priority if (!r_have_best) begin
            w_take = 1'b1;
        end else if (r3_match != r_best_matches) begin
            w_take = r3_match;
        end else if (w_dist != r_best_dist) begin
            w_take = (w_dist < r_best_dist);
        end else begin
            w_take = (r3_nidx < r_best_index);
        end
    end

    always_comb begin
        n_have_best    = r_have_best;
        n_best_matches = r_best_matches;
        n_best_dist    = r_best_dist;
        n_best_index   = r_best_index;
        if (w_take) begin
            n_have_best    = 1'b1;
            n_best_matches = r3_match;
            n_best_dist    = w_dist;
            n_best_index   = r3_nidx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_best    <= 1'b0;
            r_best_matches <= 1'b0;
            r_best_dist    <= mnns_pkg::DIST_MAX;
            r_best_index   <= '1;
        end else if (r_v3 && w_consume) begin
            if (r3_last) begin
                // group closed: drop the kept best for the next target
                r_have_best    <= 1'b0;
                r_best_matches <= 1'b0;
                r_best_dist    <= mnns_pkg::DIST_MAX;
                r_best_index   <= '1;
            end else begin
                r_have_best    <= n_have_best;
                r_best_matches <= n_best_matches;
                r_best_dist    <= n_best_dist;
                r_best_index   <= n_best_index;
            end
        end
    end

    // result register: load on a closing candidate, else drain when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_v3 && w_consume && r3_last) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v3 && w_consume && r3_last) begin
            r_o_tidx  <= r3_tidx;
            r_o_cidx  <= n_best_index;
            r_o_match <= n_best_matches;
        end
    end

    assign o_valid            = r_o_valid;
    assign o_out_target_index = r_o_tidx;
    assign o_chosen_index     = r_o_cidx;
    assign o_chosen_matches   = r_o_match;

endmodule
